[rtl/mcr_pkg.sv]
// shared widths, command codes and inter-module types for the midpoint circle rasterizer
package mcr_pkg;

    localparam int COORD_W    = 11;                 // input coordinate width
    localparam int DIFF_W     = COORD_W + 1;        // edge minus centre
    localparam int SQ_W       = 2 * DIFF_W - 1;     // sum of two squares
    localparam int ROOT_W     = SQ_W + 1;           // root and trial width in the sqrt unit
    localparam int RAD_W      = 12;                 // radius width
    localparam int POS_W      = RAD_W + 1;          // signed x and y of the walk
    localparam int DEC_W      = 16;                 // decision variable, wraps
    localparam int PT_W       = 13;                 // emitted point coordinate
    localparam int OCT_W      = 3;                  // octant index
    localparam int SQRT_STEPS = (SQ_W + 1) / 2;     // one root bit per step
    localparam int ITER_W     = $clog2(SQRT_STEPS);

    localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

    localparam logic signed [DEC_W-1:0] DEC_INIT    = 16'sd3;
    localparam logic signed [DEC_W-1:0] DEC_INC_NEG = 16'sd6;
    localparam logic signed [DEC_W-1:0] DEC_INC_POS = 16'sd10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic        [SQ_W-1:0]     sq;
    } t_cmd_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

endpackage

[rtl/mcr_front.sv]
// front end: takes input words, forms edge offsets and the squared radius
module mcr_front import mcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic signed [COORD_W-1:0]  i_edge_x,
    input  logic signed [COORD_W-1:0]  i_edge_y,
    input  t_queue_stat                i_q_stat,
    output logic                       o_push,
    output t_cmd_entry                 o_entry
);

    logic                       r_valid;
    logic                       r_command;
    logic signed [COORD_W-1:0]  r_cx;
    logic signed [COORD_W-1:0]  r_cy;
    logic signed [DIFF_W-1:0]   r_dx;
    logic signed [DIFF_W-1:0]   r_dy;

    logic                       accept;
    logic signed [2*DIFF_W-1:0] sq_x;
    logic signed [2*DIFF_W-1:0] sq_y;
    logic        [SQ_W-1:0]     sq_sum;

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && !o_push;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command <= i_command;
            r_cx      <= i_center_x;
            r_cy      <= i_center_y;
            r_dx      <= DIFF_W'(i_edge_x) - DIFF_W'(i_center_x);
            r_dy      <= DIFF_W'(i_edge_y) - DIFF_W'(i_center_y);
        end
    end

    // squared distance, always non-negative and below 2^SQ_W
    assign sq_x   = r_dx * r_dx;
    assign sq_y   = r_dy * r_dy;
    assign sq_sum = SQ_W'($unsigned(sq_x) + $unsigned(sq_y));

    always_comb begin
        o_entry.command = r_command;
        o_entry.cx      = r_cx;
        o_entry.cy      = r_cy;
        o_entry.sq      = sq_sum;
    end

endmodule

[rtl/mcr_queue.sv]
// small command fifo between front and back end
module mcr_queue import mcr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cmd_entry  i_entry,
    input  logic        i_pop,
    output t_cmd_entry  o_entry,
    output t_queue_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

endmodule

[rtl/mcr_back.sv]
// back end: radius square root, midpoint walk and eight-point emission
module mcr_back import mcr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd_entry                i_entry,
    input  t_queue_stat               i_q_stat,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [PT_W-1:0]    o_point_x,
    output logic signed [PT_W-1:0]    o_point_y,
    output logic        [OCT_W-1:0]   o_octant,
    output logic                      o_last_of_step,
    output logic                      o_circle_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQRT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                r_state;
    logic                      r_active;
    logic signed [POS_W-1:0]   r_cur_x;
    logic signed [POS_W-1:0]   r_cur_y;
    logic signed [DEC_W-1:0]   r_decision;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;

    logic [ROOT_W-1:0]         r_n;
    logic [ROOT_W-1:0]         r_root;
    logic [ROOT_W-1:0]         r_bit;
    logic [ITER_W-1:0]         r_iter;

    logic signed [POS_W-1:0]   r_ex;
    logic signed [POS_W-1:0]   r_ey;
    logic                      r_done;
    logic [OCT_W-1:0]          r_oct;

    logic                      r_out_valid;
    logic signed [PT_W-1:0]    r_pt_x;
    logic signed [PT_W-1:0]    r_pt_y;
    logic [OCT_W-1:0]          r_out_oct;
    logic                      r_out_last;
    logic                      r_out_done;

    // sqrt step
    logic [ROOT_W-1:0]         trial;
    logic                      take;
    logic [ROOT_W-1:0]         n_n;
    logic [ROOT_W-1:0]         n_root;
    logic [RAD_W-1:0]          radius;

    // walk update
    logic signed [DEC_W-1:0]   x_ext;
    logic signed [DEC_W-1:0]   y_ext;
    logic signed [DEC_W-1:0]   n_decision;
    logic signed [POS_W-1:0]   n_cur_x;
    logic signed [POS_W-1:0]   n_cur_y;
    logic                      step_done;

    // emission
    logic                      load_out;
    logic                      emit_now;
    logic signed [POS_W-1:0]   off_x;
    logic signed [POS_W-1:0]   off_y;

    assign o_pop = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign trial  = r_root + r_bit;
    assign take   = (r_n >= trial);
    assign n_n    = take ? (r_n - trial) : r_n;
    assign n_root = take ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign radius = n_root[RAD_W-1:0];

    assign x_ext = DEC_W'(r_cur_x);
    assign y_ext = DEC_W'(r_cur_y);

    always_comb begin
        n_cur_x = r_cur_x + POS_W'(1);
        if (r_decision < 0) begin
            n_decision = r_decision + (x_ext <<< 2) + DEC_INC_NEG;
            n_cur_y    = r_cur_y;
        end else begin
            n_decision = r_decision + ((x_ext - y_ext) <<< 2) + DEC_INC_POS;
            n_cur_y    = r_cur_y - POS_W'(1);
        end
        step_done = (n_cur_x > n_cur_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= 1'b0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_decision <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_iter     <= '0;
            r_oct      <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_entry.command == CMD_START) begin
                            r_cx    <= i_entry.cx;
                            r_cy    <= i_entry.cy;
                            r_iter  <= '0;
                            r_state <= ST_SQRT;
                        end else if (r_active) begin
                            r_decision <= n_decision;
                            r_cur_x    <= n_cur_x;
                            r_cur_y    <= n_cur_y;
                            if (step_done) begin
                                r_active <= 1'b0;
                            end
                            r_oct   <= '0;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_SQRT: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(SQRT_STEPS - 1)) begin
                        r_cur_x    <= '0;
                        r_cur_y    <= $signed({1'b0, radius});
                        r_decision <= DEC_INIT - $signed(DEC_W'({radius, 1'b0}));
                        r_active   <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (load_out) begin
                        r_oct <= r_oct + 1'b1;
                        if (r_oct == OCT_LAST) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // sqrt datapath and the x,y captured for a step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_pop) begin
            r_n    <= ROOT_W'(i_entry.sq);
            r_root <= '0;
            r_bit  <= ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
            r_ex   <= r_cur_x;
            r_ey   <= r_cur_y;
            r_done <= step_done;
        end else if (r_state == ST_SQRT) begin
            r_n    <= n_n;
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
        end
    end

    assign emit_now = (r_state == ST_EMIT);
    assign load_out = !r_out_valid || !i_stall;

    always_comb begin
        case (r_oct)
            3'd0:    begin off_x =  r_ex; off_y =  r_ey; end
            3'd1:    begin off_x =  r_ex; off_y = -r_ey; end
            3'd2:    begin off_x = -r_ex; off_y =  r_ey; end
            3'd3:    begin off_x = -r_ex; off_y = -r_ey; end
            3'd4:    begin off_x =  r_ey; off_y =  r_ex; end
            3'd5:    begin off_x =  r_ey; off_y = -r_ex; end
            3'd6:    begin off_x = -r_ey; off_y =  r_ex; end
            default: begin off_x = -r_ey; off_y = -r_ex; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= emit_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out && emit_now) begin
            r_pt_x     <= PT_W'(r_cx) + PT_W'(off_x);
            r_pt_y     <= PT_W'(r_cy) + PT_W'(off_y);
            r_out_oct  <= r_oct;
            r_out_last <= (r_oct == OCT_LAST);
            r_out_done <= (r_oct == OCT_LAST) && r_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_point_x      = r_pt_x;
    assign o_point_y      = r_pt_y;
    assign o_octant       = r_out_oct;
    assign o_last_of_step = r_out_last;
    assign o_circle_done  = r_out_done;

endmodule

[rtl/midpoint_circle_rasterizer_core.sv]
// midpoint circle rasterizer: step word emits eight points, start word sets up a circle
// a start is registered in the front stage, passes the fifo, is popped, then runs the square root
// a step word is popped, then its eight points leave one a cycle from the single output
// register while the receiver does not stall; a start holds the back end through the sqrt
// the back end handles one command word at a time; the fifo lets the front keep taking words
// reset: synchronous active low, clears the fifo, output valid and the circle state
module midpoint_circle_rasterizer_core import mcr_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command words
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_edge_x,
    input  logic signed [COORD_W-1:0] i_edge_y,
    // point words
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [PT_W-1:0]    o_point_x,
    output logic signed [PT_W-1:0]    o_point_y,
    output logic        [OCT_W-1:0]   o_octant,
    output logic                      o_last_of_step,
    output logic                      o_circle_done
);

    // front to fifo
    logic        push;
    t_cmd_entry  push_entry;
    // fifo to back
    logic        pop;
    t_cmd_entry  pop_entry;
    t_queue_stat q_stat;

    // front: registers the word and forms the squared edge distance
    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_edge_x   (i_edge_x),
        .i_edge_y   (i_edge_y),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decouples the front from a back end busy emitting points
    mcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (q_stat)
    );

    // back: iterative sqrt on start, midpoint update and point emission on step
    // a step with no circle in progress is dropped without output
    mcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (pop_entry),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_octant       (o_octant),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench for the midpoint circle rasterizer core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mcr_pkg::*;

    localparam int RANDOM_WORDS = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int COORD_MAX    = 1023;

    // one expected point word
    typedef struct {
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic        [OCT_W-1:0] oct;
        logic                    last;
        logic                    done;
    } t_circle_point;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_mode;

    // circle walk predictor with the queue of points it expects
    class t_circle_walk_model;
        bit                      running;
        int                      walk_x;
        int                      walk_y;
        int                      org_x;
        int                      org_y;
        logic signed [DEC_W-1:0] dec;
        t_circle_point           pending_points[$];
        int                      errors = 0;

        // note one accepted command word
        function void take_command(logic cmd, logic signed [COORD_W-1:0] cx,
                                   logic signed [COORD_W-1:0] cy,
                                   logic signed [COORD_W-1:0] ex,
                                   logic signed [COORD_W-1:0] ey);
            int            dx, dy, x, y, ox, oy;
            int unsigned   sq, root, cand;
            bit            fin;
            t_circle_point p;
            if (cmd == CMD_START) begin
                dx = int'(ex) - int'(cx);
                dy = int'(ey) - int'(cy);
                sq = dx * dx + dy * dy;
                // floor square root, one bit at a time from the top
                root = 0;
                for (int b = RAD_W - 1; b >= 0; b--) begin
                    cand = root | (32'd1 << b);
                    if (cand * cand <= sq) root = cand;
                end
                org_x   = int'(cx);
                org_y   = int'(cy);
                walk_x  = 0;
                walk_y  = int'(root);
                dec     = DEC_W'(int'(DEC_INIT) - 2 * int'(root));
                running = 1'b1;
                return;
            end
            // step with no circle in progress is ignored
            if (!running) return;
            x = walk_x;
            y = walk_y;
            // midpoint update uses x before its increment
            if (dec < 0) begin
                dec = DEC_W'(int'(dec) + 4 * x + int'(DEC_INC_NEG));
            end else begin
                dec    = DEC_W'(int'(dec) + 4 * (x - y) + int'(DEC_INC_POS));
                walk_y = y - 1;
            end
            walk_x = x + 1;
            fin    = walk_x > walk_y;
            if (fin) running = 1'b0;
            // eight mirrored points of the current x,y
            for (int k = 0; k < 8; k++) begin
                ox = (k < 4) ? x : y;
                oy = (k < 4) ? y : x;
                if (k[1]) ox = -ox;
                if (k[0]) oy = -oy;
                p.x    = PT_W'(org_x + ox);
                p.y    = PT_W'(org_y + oy);
                p.oct  = OCT_W'(k);
                p.last = (p.oct == OCT_LAST);
                p.done = p.last && fin;
                pending_points.push_back(p);
            end
        endfunction

        // compare one accepted point word with the oldest expected one
        function void check_point(t_circle_point got);
            t_circle_point want;
            if (pending_points.size() == 0) begin
                $error("unexpected point word: x %0d y %0d octant %0d",
                       got.x, got.y, got.oct);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            if (got.x !== want.x) begin
                $error("point_x: expected %0d, actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("point_y: expected %0d, actual %0d", want.y, got.y);
                errors++;
            end
            if (got.oct !== want.oct) begin
                $error("octant: expected %0d, actual %0d", want.oct, got.oct);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_step: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
            if (got.done !== want.done) begin
                $error("circle_done: expected %0d, actual %0d", want.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic                      o_stall;
    logic                      i_command  = CMD_STEP;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [COORD_W-1:0] i_edge_x   = '0;
    logic signed [COORD_W-1:0] i_edge_y   = '0;
    logic                      o_valid;
    logic                      i_stall    = 1'b0;
    logic signed [PT_W-1:0]    o_point_x;
    logic signed [PT_W-1:0]    o_point_y;
    logic        [OCT_W-1:0]   o_octant;
    logic                      o_last_of_step;
    logic                      o_circle_done;

    t_circle_walk_model walk_model = new();

    int unsigned cycle_count = 0;
    int          words_sent  = 0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    logic [7:0]  stall_mask  = '0;

    midpoint_circle_rasterizer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_edge_x       (i_edge_x),
        .i_edge_y       (i_edge_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_octant       (o_octant),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("midpoint_circle_rasterizer_core: mismatch");
        $finish;
    end

    // receiver back-pressure: a randomly chosen mode, chosen anew when its countdown runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 96);
            stall_mask <= 8'($urandom);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
            STALL_PATTERN: begin
                i_stall <= stall_mask[stall_left % 8];
            end
            default: begin
                i_stall <= ($urandom_range(0, 4) != 0);
            end
        endcase
    end

    // point word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            walk_model.check_point('{o_point_x, o_point_y, o_octant,
                                     o_last_of_step, o_circle_done});
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int v;
        v = int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
        return COORD_W'(v);
    endfunction

    // coordinate within span of base, clipped to the legal range
    function automatic logic signed [COORD_W-1:0] near_coord(int base, int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < -COORD_MAX) v = -COORD_MAX;
        return COORD_W'(v);
    endfunction

    // drive one command word and hold it until accepted
    task automatic send_word(input logic cmd,
                             input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic signed [COORD_W-1:0] ex,
                             input logic signed [COORD_W-1:0] ey);
        int gap;
        // end of a burst: drop valid for a random gap before the next word
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_center_x <= cx;
        i_center_y <= cy;
        i_edge_x   <= ex;
        i_edge_y   <= ey;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        burst_left--;
        words_sent++;
        walk_model.take_command(cmd, cx, cy, ex, ey);
    endtask

    // step word with random filler in the unused coordinates
    task automatic send_step();
        send_word(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // start a circle, then step it until it ends or max_steps is reached
    task automatic run_circle(input logic signed [COORD_W-1:0] cx,
                              input logic signed [COORD_W-1:0] cy,
                              input logic signed [COORD_W-1:0] ex,
                              input logic signed [COORD_W-1:0] ey,
                              input int max_steps);
        int n;
        send_word(CMD_START, cx, cy, ex, ey);
        n = 0;
        while (walk_model.running && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    initial begin
        int first_random;
        int pick;
        int span;
        int steps;
        logic signed [COORD_W-1:0] cx, cy;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step before any circle
        send_step();
        // zero radius at a corner, then a step with the circle over
        run_circle(-11'sd1023, 11'sd1023, -11'sd1023, 11'sd1023, 3);
        send_step();
        // largest radius, cut short by a new start
        run_circle(11'sd1023, -11'sd1023, -11'sd1023, 11'sd1023, 3);
        run_circle(11'sd0, 11'sd0, 11'sd0, 11'sd1, 3);
        // largest radius toward the other corner
        run_circle(-11'sd1023, -11'sd1023, 11'sd1023, 11'sd1023, 2);
        // small whole circles, with a large radius cut short between them
        run_circle(11'sd5, -11'sd7, 11'sd8, -11'sd3, 8);
        send_step();
        run_circle(11'sd0, 11'sd0, 11'sd1023, 11'sd0, 2);
        run_circle(-11'sd1, -11'sd1, -11'sd1, -11'sd3, 6);

        first_random = words_sent;
        while (words_sent < first_random + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // noise: any word with any content
                send_word(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord());
            end else begin
                cx = rand_coord();
                cy = rand_coord();
                pick = $urandom_range(0, 9);
                span = (pick < 7) ? 6 : (pick < 9) ? 40 : 2 * COORD_MAX;
                steps = (span > 40) ? 4 : 60;
                // sometimes a circle is abandoned part way
                if ($urandom_range(0, 5) == 0) steps = $urandom_range(1, 3);
                run_circle(cx, cy, near_coord(int'(cx), span), near_coord(int'(cy), span),
                           steps);
                if ($urandom_range(0, 3) == 0) send_step();
            end
        end
        i_valid <= 1'b0;

        // drain outstanding points, then watch for strays
        while (walk_model.pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (walk_model.errors == 0 && walk_model.pending_points.size() == 0) begin
            $display("midpoint_circle_rasterizer_core: match");
        end else begin
            $display("midpoint_circle_rasterizer_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_core.sv
test/tb_top.sv
